// ===== design/p2c_pkg.sv =====
// ----------------------------------------------------------------------------
// p2c_pkg: shared constants and types for the point-to-circle pose unit
// Widths, CORDIC angle table, register indexes and pipeline control struct.
// ----------------------------------------------------------------------------
package p2c_pkg;

   localparam int COORD_BITS_DEF  = 32;
   localparam int ANGLE_STEPS_DEF = 16;
   localparam int MAX_STEPS       = 32;

   localparam int COORD_W    = 32;
   localparam int RADIUS_W   = 31;
   localparam int QUAT_W     = 16;
   localparam int DIFF_W     = 33;
   localparam int NORM_W     = 42;
   localparam int MAG_W      = 41;
   localparam int VEC_W      = 45;
   localparam int ANG_W      = 32;
   localparam int ROT_W      = 34;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS   = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;
   localparam logic signed [ROT_W-1:0] GAIN_INV = 34'sd652032874;
   localparam logic signed [ANG_W-1:0] QUARTER  = 32'sh4000_0000;
   localparam logic signed [ANG_W-1:0] NQUARTER = 32'shC000_0000;
   localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

   localparam logic [ANG_W-1:0] ATAN_TURNS [0:MAX_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
      32'h00000000, 32'h00000000
   };

   typedef struct packed {
      logic valid;
      logic at_center;
   } ctl_type;

   function automatic int clamp_steps(input int n);
      return (n > MAX_STEPS) ? MAX_STEPS : ((n < 1) ? 1 : n);
   endfunction

endpackage

// ===== design/p2c_norm.sv =====
// ----------------------------------------------------------------------------
// p2c_norm: offset from centre and normalisation
// Three stages: difference and centre test, then a two-stage left shift that
// brings the larger magnitude into [2^40, 2^41).
// ----------------------------------------------------------------------------
module p2c_norm (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 valid_in,
   input  logic signed [p2c_pkg::COORD_W-1:0]   point_x,
   input  logic signed [p2c_pkg::COORD_W-1:0]   point_y,
   input  logic signed [p2c_pkg::COORD_W-1:0]   center_x,
   input  logic signed [p2c_pkg::COORD_W-1:0]   center_y,
   output p2c_pkg::ctl_type                     ctl_out,
   output logic signed [p2c_pkg::NORM_W-1:0]    dx_out,
   output logic signed [p2c_pkg::NORM_W-1:0]    dy_out
);
   import p2c_pkg::*;

   ctl_type                   ctl1_ff, ctl2_ff, ctl3_ff;
   ctl_type                   ctl1_in;
   logic signed [DIFF_W-1:0]  dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic signed [NORM_W-1:0]  dx2_ff, dy2_ff, dx2_in, dy2_in;
   logic signed [NORM_W-1:0]  dx3_ff, dy3_ff, dx3_in, dy3_in;
   logic [MAG_W-1:0]          m2_ff, m2_in;

   always_comb begin
      dx1_in = DIFF_W'(point_x) - DIFF_W'(center_x);
      dy1_in = DIFF_W'(point_y) - DIFF_W'(center_y);
      ctl1_in.valid     = valid_in;
      ctl1_in.at_center = (dx1_in == '0) && (dy1_in == '0);
   end

   always_comb begin
      logic signed [NORM_W-1:0] ax, ay;
      logic [MAG_W-1:0]         m;
      logic signed [NORM_W-1:0] x, y;
      x  = NORM_W'(dx1_ff);
      y  = NORM_W'(dy1_ff);
      ax = x[NORM_W-1] ? -x : x;
      ay = y[NORM_W-1] ? -y : y;
      m  = (ay > ax) ? MAG_W'(ay) : MAG_W'(ax);
      for (int j = 0; j < 3; j++) begin
         if (m < (MAG_W'(1) << (MAG_W - (32 >> j)))) begin
            m = m << (32 >> j);
            x = x <<< (32 >> j);
            y = y <<< (32 >> j);
         end
      end
      m2_in  = m;
      dx2_in = x;
      dy2_in = y;
   end

   always_comb begin
      logic [MAG_W-1:0]         m;
      logic signed [NORM_W-1:0] x, y;
      m = m2_ff;
      x = dx2_ff;
      y = dy2_ff;
      for (int j = 0; j < 3; j++) begin
         if (m < (MAG_W'(1) << (MAG_W - (4 >> j)))) begin
            m = m << (4 >> j);
            x = x <<< (4 >> j);
            y = y <<< (4 >> j);
         end
      end
      dx3_in = x;
      dy3_in = y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
         dx2_ff <= dx2_in;
         dy2_ff <= dy2_in;
         m2_ff  <= m2_in;
         dx3_ff <= dx3_in;
         dy3_ff <= dy3_in;
      end
   end

   assign ctl_out = ctl3_ff;
   assign dx_out  = dx3_ff;
   assign dy_out  = dy3_ff;

endmodule

// ===== design/p2c_vec.sv =====
// ----------------------------------------------------------------------------
// p2c_vec: vectoring CORDIC
// One stage per micro-rotation gives the direction angle; a last stage folds
// it into the edge rotation angle and the half-yaw angle.
// ----------------------------------------------------------------------------
module p2c_vec #(
   parameter int STEPS = p2c_pkg::ANGLE_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  p2c_pkg::ctl_type                     ctl_in,
   input  logic signed [p2c_pkg::NORM_W-1:0]    dx_in,
   input  logic signed [p2c_pkg::NORM_W-1:0]    dy_in,
   output p2c_pkg::ctl_type                     ctl_out,
   output logic                                 flip_out,
   output logic signed [p2c_pkg::ANG_W-1:0]     t_out,
   output logic signed [p2c_pkg::ANG_W-1:0]     h_out
);
   import p2c_pkg::*;

   ctl_type                  ctl_ff [0:STEPS];
   logic signed [VEC_W-1:0]  x_ff [0:STEPS];
   logic signed [VEC_W-1:0]  y_ff [0:STEPS];
   logic [ANG_W-1:0]         z_ff [0:STEPS];
   logic signed [VEC_W-1:0]  x0_in, y0_in;
   logic [ANG_W-1:0]         z0_in;

   ctl_type                  ctlp_ff;
   logic                     flip_ff, flip_in;
   logic signed [ANG_W-1:0]  t_ff, t_in, h_ff, h_in;

   always_comb begin
      x0_in = VEC_W'(dx_in);
      y0_in = VEC_W'(dy_in);
      z0_in = '0;
      if (dx_in[NORM_W-1]) begin
         x0_in = -x0_in;
         y0_in = -y0_in;
         z0_in = HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         z_ff[0] <= z0_in;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [VEC_W-1:0] xs, ys, x_in, y_in;
      logic [ANG_W-1:0]        z_in;

      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;

      always_comb begin
         if (!y_ff[i][VEC_W-1] && (y_ff[i] != '0)) begin
            x_in = x_ff[i] + ys;
            y_in = y_ff[i] - xs;
            z_in = z_ff[i] + ATAN_TURNS[i];
         end else begin
            x_in = x_ff[i] - ys;
            y_in = y_ff[i] + xs;
            z_in = z_ff[i] - ATAN_TURNS[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i+1] <= '0;
         end else if (adv) begin
            ctl_ff[i+1] <= ctl_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
         end
      end
   end

   always_comb begin
      logic signed [ANG_W-1:0] theta, yaw, yaw_adj;
      theta   = signed'(z_ff[STEPS]);
      flip_in = (theta > QUARTER) || (theta < NQUARTER);
      t_in    = flip_in ? {~theta[ANG_W-1], theta[ANG_W-2:0]} : theta;
      yaw     = {~theta[ANG_W-1], theta[ANG_W-2:0]};
      yaw_adj = yaw + ANG_W'({yaw[ANG_W-1]});
      h_in    = (yaw == signed'(HALF_TURN)) ? QUARTER : (yaw_adj >>> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctlp_ff <= '0;
      end else if (adv) begin
         ctlp_ff <= ctl_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flip_ff <= flip_in;
         t_ff    <= t_in;
         h_ff    <= h_in;
      end
   end

   assign ctl_out  = ctlp_ff;
   assign flip_out = flip_ff;
   assign t_out    = t_ff;
   assign h_out    = h_ff;

endmodule

// ===== design/p2c_rot.sv =====
// ----------------------------------------------------------------------------
// p2c_rot: dual-lane rotation CORDIC
// Lane e gives cosine and sine of the edge angle, lane q those of the half
// yaw; both at scale 2^30, one stage per micro-rotation.
// ----------------------------------------------------------------------------
module p2c_rot #(
   parameter int STEPS = p2c_pkg::ANGLE_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  p2c_pkg::ctl_type                     ctl_in,
   input  logic                                 flip_in,
   input  logic signed [p2c_pkg::ANG_W-1:0]     te_in,
   input  logic signed [p2c_pkg::ANG_W-1:0]     tq_in,
   output p2c_pkg::ctl_type                     ctl_out,
   output logic                                 flip_out,
   output logic signed [p2c_pkg::ROT_W-1:0]     ce_out,
   output logic signed [p2c_pkg::ROT_W-1:0]     se_out,
   output logic signed [p2c_pkg::ROT_W-1:0]     cq_out,
   output logic signed [p2c_pkg::ROT_W-1:0]     sq_out
);
   import p2c_pkg::*;

   localparam int Z_W = ANG_W + 1;

   ctl_type                  ctl_ff  [0:STEPS];
   logic                     flip_ff [0:STEPS];
   logic signed [ROT_W-1:0]  xe_ff [0:STEPS];
   logic signed [ROT_W-1:0]  ye_ff [0:STEPS];
   logic signed [Z_W-1:0]    ze_ff [0:STEPS];
   logic signed [ROT_W-1:0]  xq_ff [0:STEPS];
   logic signed [ROT_W-1:0]  yq_ff [0:STEPS];
   logic signed [Z_W-1:0]    zq_ff [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         flip_ff[0] <= flip_in;
         xe_ff[0]   <= GAIN_INV;
         ye_ff[0]   <= '0;
         ze_ff[0]   <= Z_W'(te_in);
         xq_ff[0]   <= GAIN_INV;
         yq_ff[0]   <= '0;
         zq_ff[0]   <= Z_W'(tq_in);
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [ROT_W-1:0] xes, yes, xqs, yqs;
      logic signed [ROT_W-1:0] xe_in, ye_in, xq_in, yq_in;
      logic signed [Z_W-1:0]   ze_in, zq_in, at;

      assign xes = xe_ff[i] >>> i;
      assign yes = ye_ff[i] >>> i;
      assign xqs = xq_ff[i] >>> i;
      assign yqs = yq_ff[i] >>> i;
      assign at  = signed'({1'b0, ATAN_TURNS[i]});

      always_comb begin
         if (!ze_ff[i][Z_W-1]) begin
            xe_in = xe_ff[i] - yes;
            ye_in = ye_ff[i] + xes;
            ze_in = ze_ff[i] - at;
         end else begin
            xe_in = xe_ff[i] + yes;
            ye_in = ye_ff[i] - xes;
            ze_in = ze_ff[i] + at;
         end
         if (!zq_ff[i][Z_W-1]) begin
            xq_in = xq_ff[i] - yqs;
            yq_in = yq_ff[i] + xqs;
            zq_in = zq_ff[i] - at;
         end else begin
            xq_in = xq_ff[i] + yqs;
            yq_in = yq_ff[i] - xqs;
            zq_in = zq_ff[i] + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i+1] <= '0;
         end else if (adv) begin
            ctl_ff[i+1] <= ctl_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            flip_ff[i+1] <= flip_ff[i];
            xe_ff[i+1]   <= xe_in;
            ye_ff[i+1]   <= ye_in;
            ze_ff[i+1]   <= ze_in;
            xq_ff[i+1]   <= xq_in;
            yq_ff[i+1]   <= yq_in;
            zq_ff[i+1]   <= zq_in;
         end
      end
   end

   assign ctl_out  = ctl_ff[STEPS];
   assign flip_out = flip_ff[STEPS];
   assign ce_out   = xe_ff[STEPS];
   assign se_out   = ye_ff[STEPS];
   assign cq_out   = xq_ff[STEPS];
   assign sq_out   = yq_ff[STEPS];

endmodule

// ===== design/p2c_out.sv =====
// ----------------------------------------------------------------------------
// p2c_out: scaling, rounding and saturation
// Sign fold and quaternion rounding, radius multiply, then centre offset and
// clamp into the output register.
// ----------------------------------------------------------------------------
module p2c_out #(
   parameter int COORD_BITS = p2c_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  p2c_pkg::ctl_type                     ctl_in,
   input  logic                                 flip_in,
   input  logic signed [p2c_pkg::ROT_W-1:0]     ce_in,
   input  logic signed [p2c_pkg::ROT_W-1:0]     se_in,
   input  logic signed [p2c_pkg::ROT_W-1:0]     cq_in,
   input  logic signed [p2c_pkg::ROT_W-1:0]     sq_in,
   input  logic signed [p2c_pkg::COORD_W-1:0]   center_x,
   input  logic signed [p2c_pkg::COORD_W-1:0]   center_y,
   input  logic [p2c_pkg::RADIUS_W-1:0]         circle_radius,
   output logic                                 valid_out,
   output logic                                 at_center,
   output logic signed [p2c_pkg::COORD_W-1:0]   edge_x,
   output logic signed [p2c_pkg::COORD_W-1:0]   edge_y,
   output logic signed [p2c_pkg::QUAT_W-1:0]    quat_z,
   output logic signed [p2c_pkg::QUAT_W-1:0]    quat_w
);
   import p2c_pkg::*;

   localparam int SAT_BITS = (COORD_BITS > 32) ? 32 : ((COORD_BITS < 2) ? 2 : COORD_BITS);
   localparam int PROD_W   = ROT_W + RADIUS_W + 1;
   localparam int SUM_W    = PROD_W - 30 + 1;
   localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (SAT_BITS - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
   localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) <<< 29;

   function automatic logic signed [QUAT_W-1:0] q15(input logic signed [ROT_W-1:0] v);
      logic signed [ROT_W:0]    r;
      logic signed [ROT_W-15:0] q;
      r = (ROT_W+1)'(v) + (ROT_W+1)'(16384);
      q = r[ROT_W:15];
      if (q > (ROT_W-14)'(32767)) begin
         return 16'sh7FFF;
      end else if (q < -(ROT_W-14)'(32768)) begin
         return 16'sh8000;
      end else begin
         return q[QUAT_W-1:0];
      end
   endfunction

   function automatic logic signed [COORD_W-1:0] edge_calc(
      input logic signed [PROD_W-1:0]  p,
      input logic signed [COORD_W-1:0] c
   );
      logic signed [PROD_W-1:0] r;
      logic signed [SUM_W-1:0]  s;
      r = p + RND;
      s = SUM_W'(c) + SUM_W'(signed'(r[PROD_W-1:30]));
      if (s > SAT_HI) begin
         s = SAT_HI;
      end else if (s < SAT_LO) begin
         s = SAT_LO;
      end
      return s[COORD_W-1:0];
   endfunction

   ctl_type                    ctla_ff, ctlb_ff;
   logic signed [ROT_W-1:0]    cf_ff, sf_ff, cf_in, sf_in;
   logic signed [QUAT_W-1:0]   qza_ff, qwa_ff, qzb_ff, qwb_ff;
   logic signed [PROD_W-1:0]   px_ff, py_ff, px_in, py_in;
   logic                       valid_ff, at_center_ff;
   logic signed [COORD_W-1:0]  ex_ff, ey_ff, ex_in, ey_in;
   logic signed [QUAT_W-1:0]   qz_ff, qw_ff, qz_in, qw_in;

   assign cf_in = flip_in ? -ce_in : ce_in;
   assign sf_in = flip_in ? -se_in : se_in;

   assign px_in = PROD_W'(signed'({1'b0, circle_radius})) * PROD_W'(cf_ff);
   assign py_in = PROD_W'(signed'({1'b0, circle_radius})) * PROD_W'(sf_ff);

   always_comb begin
      if (ctlb_ff.at_center) begin
         ex_in = '0;
         ey_in = '0;
         qz_in = '0;
         qw_in = '0;
      end else begin
         ex_in = edge_calc(px_ff, center_x);
         ey_in = edge_calc(py_ff, center_y);
         qz_in = qzb_ff;
         qw_in = qwb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctla_ff      <= '0;
         ctlb_ff      <= '0;
         valid_ff     <= 1'b0;
         at_center_ff <= 1'b0;
      end else if (adv) begin
         ctla_ff      <= ctl_in;
         ctlb_ff      <= ctla_ff;
         valid_ff     <= ctlb_ff.valid;
         at_center_ff <= ctlb_ff.at_center;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cf_ff  <= cf_in;
         sf_ff  <= sf_in;
         qza_ff <= q15(sq_in);
         qwa_ff <= q15(cq_in);
         px_ff  <= px_in;
         py_ff  <= py_in;
         qzb_ff <= qza_ff;
         qwb_ff <= qwa_ff;
         ex_ff  <= ex_in;
         ey_ff  <= ey_in;
         qz_ff  <= qz_in;
         qw_ff  <= qw_in;
      end
   end

   assign valid_out = valid_ff;
   assign at_center = at_center_ff;
   assign edge_x    = ex_ff;
   assign edge_y    = ey_ff;
   assign quat_z    = qz_ff;
   assign quat_w    = qw_ff;

endmodule

// ===== design/point_to_circle_pose_unit.sv =====
// ----------------------------------------------------------------------------
// point_to_circle_pose_unit: radial projection onto a circle with yaw pose
// Projects each point onto the configured circle and returns the boundary
// point and a yaw-only quaternion facing the centre.
// ----------------------------------------------------------------------------
// Takes one point per clock unless a result is stalled, and returns one result per
// point, in order. The path runs through three normalisation stages, the vectoring
// CORDIC with an entry stage, one stage per micro-rotation and an angle fold stage,
// the rotation CORDIC (edge and half-yaw lanes side by side) with an entry stage and
// one stage per micro-rotation, and three stages of multiply, round and clamp ending
// in the output register. A stalled result stalls the whole pipeline.
// A point equal to the centre returns at_center with all other fields zero.
// Write the centre and radius only while no item is in flight.
module point_to_circle_pose_unit #(
   parameter int COORD_BITS  = p2c_pkg::COORD_BITS_DEF,
   parameter int ANGLE_STEPS = p2c_pkg::ANGLE_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [63:0]                          req_tdata,  // point_x, point_y
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [95:0]                          rsp_tdata,  // edge_x, edge_y, quat_z, quat_w
   output logic [0:0]                           rsp_tuser,  // at_center
   input  logic                                 csr_we,
   input  logic [p2c_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [p2c_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import p2c_pkg::*;

   localparam int STEPS = clamp_steps(ANGLE_STEPS);

   logic                        adv;
   logic signed [COORD_W-1:0]   center_x_ff, center_y_ff;
   logic [RADIUS_W-1:0]         radius_ff;

   ctl_type                     n_ctl, v_ctl, r_ctl;
   logic signed [NORM_W-1:0]    n_dx, n_dy;
   logic                        v_flip, r_flip;
   logic signed [ANG_W-1:0]     v_t, v_h;
   logic signed [ROT_W-1:0]     r_ce, r_se, r_cq, r_sq;
   logic                        o_valid, o_at_center;
   logic signed [COORD_W-1:0]   o_ex, o_ey;
   logic signed [QUAT_W-1:0]    o_qz, o_qw;

   assign adv        = rsp_tready || !o_valid;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= RADIUS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CENTER_X: center_x_ff <= signed'(csr_wdata);
            CSR_CENTER_Y: center_y_ff <= signed'(csr_wdata);
            CSR_RADIUS:   radius_ff   <= csr_wdata[RADIUS_W-1:0];
            default:      ;
         endcase
      end
   end

   p2c_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .valid_in (req_tvalid),
      .point_x  (signed'(req_tdata[31:0])),
      .point_y  (signed'(req_tdata[63:32])),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .ctl_out  (n_ctl),
      .dx_out   (n_dx),
      .dy_out   (n_dy)
   );

   p2c_vec #(.STEPS(STEPS)) u_vec (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .ctl_in   (n_ctl),
      .dx_in    (n_dx),
      .dy_in    (n_dy),
      .ctl_out  (v_ctl),
      .flip_out (v_flip),
      .t_out    (v_t),
      .h_out    (v_h)
   );

   p2c_rot #(.STEPS(STEPS)) u_rot (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .ctl_in   (v_ctl),
      .flip_in  (v_flip),
      .te_in    (v_t),
      .tq_in    (v_h),
      .ctl_out  (r_ctl),
      .flip_out (r_flip),
      .ce_out   (r_ce),
      .se_out   (r_se),
      .cq_out   (r_cq),
      .sq_out   (r_sq)
   );

   p2c_out #(.COORD_BITS(COORD_BITS)) u_out (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .ctl_in        (r_ctl),
      .flip_in       (r_flip),
      .ce_in         (r_ce),
      .se_in         (r_se),
      .cq_in         (r_cq),
      .sq_in         (r_sq),
      .center_x      (center_x_ff),
      .center_y      (center_y_ff),
      .circle_radius (radius_ff),
      .valid_out     (o_valid),
      .at_center     (o_at_center),
      .edge_x        (o_ex),
      .edge_y        (o_ey),
      .quat_z        (o_qz),
      .quat_w        (o_qw)
   );

   assign rsp_tvalid = o_valid;
   assign rsp_tdata  = {o_qw, o_qz, o_ey, o_ex};
   assign rsp_tuser  = o_at_center;

`ifndef ASSERT_OFF
   a_centre_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("centre result carries non-zero fields");

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input held off without an output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: point_to_circle_pose_unit
// Streams points at the pose unit under random idling and back-pressure,
// predicts the boundary point and heading quaternion per point with a
// CORDIC model of its own, and checks every result field in order.
// ----------------------------------------------------------------------------
module testbench;
   import p2c_pkg::*;

   localparam int STEPS = 16;
   localparam int LATENCY = 2 * STEPS + 9;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic signed [31:0] edge_x;
      logic signed [31:0] edge_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic               at_center;
   } pose_type;

   class pose_scoreboard;
      longint cx, cy, rad;
      pose_type pending[$];
      int errors;

      function new();
         cx = 0;
         cy = 0;
         rad = 65536;
         errors = 0;
      endfunction

      function longint asr(longint v, int s);
         return v >>> s;
      endfunction

      function longint wrap32(longint a);
         return longint'(signed'(a[31:0]));
      endfunction

      function longint heading(longint x, longint y);
         longint z, xs, ys;
         z = 0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd2147483648;
         end
         for (int i = 0; i < STEPS; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y > 0) begin
               x = x + ys;
               y = y - xs;
               z += longint'(ATAN_TURNS[i]);
            end else begin
               x = x - ys;
               y = y + xs;
               z -= longint'(ATAN_TURNS[i]);
            end
         end
         return wrap32(z);
      endfunction

      function void sincos(longint z, output longint c, output longint s);
         longint x, y, xs, ys;
         x = 652032874;
         y = 0;
         for (int i = 0; i < STEPS; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z -= longint'(ATAN_TURNS[i]);
            end else begin
               x = x + ys;
               y = y - xs;
               z += longint'(ATAN_TURNS[i]);
            end
         end
         c = x;
         s = y;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void configure(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_CENTER_X: cx = longint'(signed'(val));
            CSR_CENTER_Y: cy = longint'(signed'(val));
            CSR_RADIUS: rad = longint'(val[30:0]);
            default: ;
         endcase
      endfunction

      function void note_point(logic [31:0] px, logic [31:0] py);
         longint dx, dy, m, ay, th, t, c, s, yaw, h;
         bit flip;
         pose_type p;
         dx = longint'(signed'(px)) - cx;
         dy = longint'(signed'(py)) - cy;
         p = '{0, 0, 0, 0, 0};
         if (dx == 0 && dy == 0) begin
            p.at_center = 1;
            pending = {pending, p};
            return;
         end
         m = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         if (ay > m) m = ay;
         while (m < (64'sd1 << 40)) begin
            m *= 2;
            dx *= 2;
            dy *= 2;
         end
         th = heading(dx, dy);
         t = th;
         flip = 0;
         if (t > 64'sd1073741824) begin
            t -= 64'sd2147483648;
            flip = 1;
         end else if (t < -64'sd1073741824) begin
            t += 64'sd2147483648;
            flip = 1;
         end
         sincos(t, c, s);
         if (flip) begin
            c = -c;
            s = -s;
         end
         p.edge_x = 32'(clip(cx + asr(rad * c + (64'sd1 << 29), 30), -64'sd2147483648,
                             64'sd2147483647));
         p.edge_y = 32'(clip(cy + asr(rad * s + (64'sd1 << 29), 30), -64'sd2147483648,
                             64'sd2147483647));
         yaw = wrap32(th + 64'sd2147483648);
         h = (yaw == -64'sd2147483648) ? 64'sd1073741824 : yaw / 2;
         sincos(h, c, s);
         p.quat_z = 16'(clip(asr(s + (64'sd1 << 14), 15), -32768, 32767));
         p.quat_w = 16'(clip(asr(c + (64'sd1 << 14), 15), -32768, 32767));
         pending = {pending, p};
      endfunction

      function void check_pose(logic [95:0] d, logic u);
         pose_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %h", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[31:0] !== e.edge_x) begin
            $error("edge_x exp %h got %h", e.edge_x, d[31:0]);
            errors++;
         end
         if (d[63:32] !== e.edge_y) begin
            $error("edge_y exp %h got %h", e.edge_y, d[63:32]);
            errors++;
         end
         if (d[79:64] !== e.quat_z) begin
            $error("quat_z exp %h got %h", e.quat_z, d[79:64]);
            errors++;
         end
         if (d[95:80] !== e.quat_w) begin
            $error("quat_w exp %h got %h", e.quat_w, d[95:80]);
            errors++;
         end
         if (u !== e.at_center) begin
            $error("at_center exp %b got %b", e.at_center, u);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_we = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pose_scoreboard board = new();
   bit quiet = 0;
   bit hold_off = 0;
   int idle_cycles = 0;

   always #10 clock = ~clock;

   point_to_circle_pose_unit dut (.*);

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_point(req_tdata[31:0], req_tdata[63:32]);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_pose(rsp_tdata, rsp_tuser[0]);
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_off) begin
         rsp_tready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 0;
         repeat ($urandom_range(1, 3) - 1) @(posedge clock);
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.configure(idx, val);
      csr_we <= 0;
   endtask

   task automatic send_point(logic [31:0] px, logic [31:0] py);
      if (!quiet && $urandom_range(0, 6) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {py, px};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return 32'(signed'($urandom_range(0, 2000)) - 1000);
         2: return board.cx[31:0] + 32'(signed'($urandom_range(0, 6)) - 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_points(int n);
      logic [31:0] px, py;
      for (int i = 0; i < n; i++) begin
         px = rand_coord();
         py = rand_coord();
         if ($urandom_range(0, 15) == 0) begin
            px = board.cx[31:0];
            py = board.cy[31:0];
         end
         send_point(px, py);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_point(0, 0);
      send_point(32'h0001_0000, 0);
      send_point(32'hFFFF_0000, 0);
      send_point(0, 32'h0001_0000);
      send_point(0, 32'hFFFF_0000);
      send_point(32'hFFFF_0000, 32'h0000_0001);
      send_point(32'hFFFF_0000, 32'hFFFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(1, 0);
      send_point(32'h0000_0005, 32'hFFFF_FFFB);
      drain();

      write_reg(CSR_CENTER_X, 32'h7FFF_FFFF);
      write_reg(CSR_CENTER_Y, 32'h8000_0000);
      write_reg(CSR_RADIUS, 32'h7FFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(0, 0);
      drain();

      write_reg(CSR_RADIUS, 0);
      write_reg(CSR_CENTER_X, 32'h8000_0000);
      write_reg(CSR_CENTER_Y, 32'h7FFF_FFFF);
      send_point(0, 0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         write_reg(CSR_CENTER_X, phase == 0 ? 32'h0 : $urandom);
         write_reg(CSR_CENTER_Y, phase == 0 ? 32'h0 : $urandom);
         write_reg(CSR_RADIUS, phase == 1 ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0100_0000));
         if (phase == 2) begin
            fork
               begin
                  hold_off = 1;
                  repeat (200) @(posedge clock);
                  hold_off = 0;
               end
               random_points(300);
            join
         end else begin
            if (phase == 5) quiet = 1;
            random_points(300);
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule
